// ----- sv/wpp_pkg.sv -----
// shared types and constants of the wav pcm stream parser
package wpp_pkg;

  // queue between the byte front end and the parser
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueueAw    = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCw    = $clog2(QueueDepth + 1);

  // riff/fmt header layout
  localparam logic [5:0]  HeaderLen = 6'd36;
  localparam logic [31:0] DataTag   = 32'h6461_7461;
  localparam logic [15:0] PcmBits   = 16'd16;

  // stream widths
  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 1;
  localparam int unsigned OutDataW = 112;
  localparam int unsigned OutUserW = 3;

  typedef enum logic [1:0] {
    KIND_SAMPLE    = 2'd0,
    KIND_HEADER    = 2'd1,
    KIND_NO_DATA   = 2'd2,
    KIND_BAD_WIDTH = 2'd3
  } kind_e;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_SEARCH  = 5'b00010,
    PH_LENGTH  = 5'b00100,
    PH_SAMPLES = 5'b01000,
    PH_IDLE    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] sample;
    logic [15:0]        channel;
    logic               frame_last;
    logic               data_last;
    logic [31:0]        sample_rate;
    logic [15:0]        channel_count;
    logic [31:0]        data_bytes;
  } result_t;

endpackage

// ----- sv/wpp_queue.sv -----
// front end: byte request queue that decouples the input stream from the parser
module wpp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wpp_pkg::in_item_t push_item_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output wpp_pkg::in_item_t pop_item_o
);

  wpp_pkg::in_item_t                 mem_q [wpp_pkg::QueueDepth];
  logic [wpp_pkg::QueueAw-1:0]       wr_ptr_q, wr_ptr_d;
  logic [wpp_pkg::QueueAw-1:0]       rd_ptr_q, rd_ptr_d;
  logic [wpp_pkg::QueueCw-1:0]       count_q, count_d;
  logic                              do_push;
  logic                              do_pop;

  assign full_o     = (count_q == wpp_pkg::QueueCw'(wpp_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == wpp_pkg::QueueAw'(wpp_pkg::QueueDepth - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == wpp_pkg::QueueAw'(wpp_pkg::QueueDepth - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // fill count never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wpp_pkg::QueueCw'(wpp_pkg::QueueDepth))
    else $error("queue count beyond depth");

  // a lone push raises the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");

  // a lone pop lowers the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count missed a pop");

endmodule

// ----- sv/wpp_parser.sv -----
// back end: header, data tag search and sample assembly with an output register
module wpp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  wpp_pkg::in_item_t item_i,
  output logic              item_pop_o,
  output logic              result_valid_o,
  output wpp_pkg::result_t  result_o,
  input  logic              result_ready_i
);

  wpp_pkg::phase_e   phase_q, phase_d;
  logic [31:0]       offset_q, offset_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              bos_q, bos_d;
  logic [15:0]       chan_q, chan_d;
  logic [31:0]       window_q, window_d;
  logic [31:0]       chunk_q, chunk_d;
  logic [31:0]       rate_q, rate_d;
  logic [15:0]       chans_q, chans_d;
  logic [15:0]       bits_q, bits_d;
  logic [31:0]       remain_q, remain_d;
  logic [7:0]        low_q, low_d;
  logic              out_valid_q, out_valid_d;
  wpp_pkg::result_t  out_q, out_d;

  wpp_pkg::phase_e   phase_eff;
  logic [31:0]       offset_eff;
  logic [7:0]        b;
  logic              advance;
  logic              emit;
  wpp_pkg::result_t  res;

  assign b          = item_i.data_byte;
  assign advance    = item_valid_i && (!out_valid_q || result_ready_i);
  assign item_pop_o = advance;
  assign phase_eff  = item_i.file_start ? wpp_pkg::PH_HEADER : phase_q;
  assign offset_eff = item_i.file_start ? 32'd0 : offset_q;

  // per-byte parse step
  always_comb begin
    logic [31:0] win_n;
    logic [31:0] rem_full;
    logic [31:0] rem_n;
    logic        fl;
    win_n    = {window_q[23:0], b};
    rem_full = {b, remain_q[23:0]};
    rem_n    = remain_q - 32'd1;
    fl       = ({1'b0, chan_q} + 17'd1) >= {1'b0, chans_q};
    phase_d  = phase_q;
    offset_d = offset_q;
    cnt_d    = cnt_q;
    bos_d    = bos_q;
    chan_d   = chan_q;
    window_d = window_q;
    chunk_d  = chunk_q;
    rate_d   = rate_q;
    chans_d  = chans_q;
    bits_d   = bits_q;
    remain_d = remain_q;
    low_d    = low_q;
    emit     = 1'b0;
    res      = '0;
    res.kind = wpp_pkg::KIND_SAMPLE;
    unique case (phase_eff)
      wpp_pkg::PH_HEADER: begin
        bos_d = 1'b0;
        case (offset_eff[5:0])
          6'd4:  chunk_d[7:0]   = b;
          6'd5:  chunk_d[15:8]  = b;
          6'd6:  chunk_d[23:16] = b;
          6'd7:  chunk_d[31:24] = b;
          6'd22: chans_d[7:0]   = b;
          6'd23: chans_d[15:8]  = b;
          6'd24: rate_d[7:0]    = b;
          6'd25: rate_d[15:8]   = b;
          6'd26: rate_d[23:16]  = b;
          6'd27: rate_d[31:24]  = b;
          6'd34: bits_d[7:0]    = b;
          6'd35: bits_d[15:8]   = b;
          default: ;
        endcase
        if (offset_eff[5:0] == wpp_pkg::HeaderLen - 6'd1) begin
          phase_d  = wpp_pkg::PH_SEARCH;
          offset_d = {26'd0, wpp_pkg::HeaderLen};
          cnt_d    = 2'd0;
        end else begin
          phase_d  = wpp_pkg::PH_HEADER;
          offset_d = offset_eff + 32'd1;
        end
      end
      wpp_pkg::PH_SEARCH: begin
        window_d = win_n;
        if (cnt_q != 2'd3) begin
          cnt_d = cnt_q + 2'd1;
        end else if (win_n == wpp_pkg::DataTag) begin
          phase_d = wpp_pkg::PH_LENGTH;
          cnt_d   = 2'd0;
        end else if (offset_q >= chunk_q) begin
          phase_d  = wpp_pkg::PH_IDLE;
          emit     = 1'b1;
          res.kind = wpp_pkg::KIND_NO_DATA;
        end else begin
          offset_d = offset_q + 32'd1;
        end
      end
      wpp_pkg::PH_LENGTH: begin
        case (cnt_q)
          2'd0:    remain_d[7:0]   = b;
          2'd1:    remain_d[15:8]  = b;
          2'd2:    remain_d[23:16] = b;
          default: remain_d[31:24] = b;
        endcase
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          emit = 1'b1;
          if (bits_q != wpp_pkg::PcmBits) begin
            phase_d  = wpp_pkg::PH_IDLE;
            res.kind = wpp_pkg::KIND_BAD_WIDTH;
          end else begin
            res.kind          = wpp_pkg::KIND_HEADER;
            res.sample_rate   = rate_q;
            res.channel_count = chans_q;
            res.data_bytes    = rem_full;
            phase_d = (rem_full == 32'd0) ? wpp_pkg::PH_IDLE : wpp_pkg::PH_SAMPLES;
            bos_d   = 1'b0;
            chan_d  = 16'd0;
          end
        end
      end
      wpp_pkg::PH_SAMPLES: begin
        remain_d = rem_n;
        if (!bos_q) begin
          low_d = b;
          bos_d = 1'b1;
        end else begin
          bos_d          = 1'b0;
          emit           = 1'b1;
          res.kind       = wpp_pkg::KIND_SAMPLE;
          res.sample     = {b, low_q};
          res.channel    = chan_q;
          res.frame_last = fl;
          res.data_last  = (rem_n == 32'd0);
          chan_d         = fl ? 16'd0 : chan_q + 16'd1;
        end
        if (rem_n == 32'd0) begin
          phase_d = wpp_pkg::PH_IDLE;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = emit;
      if (emit) begin
        out_d = res;
      end
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign result_valid_o = out_valid_q;
  assign result_o       = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wpp_pkg::PH_HEADER;
      offset_q    <= '0;
      cnt_q       <= '0;
      bos_q       <= 1'b0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        phase_q  <= phase_d;
        offset_q <= offset_d;
        cnt_q    <= cnt_d;
        bos_q    <= bos_d;
        chan_q   <= chan_d;
      end
    end
  end

  // captured fields and payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (advance) begin
      window_q <= window_d;
      chunk_q  <= chunk_d;
      rate_q   <= rate_d;
      chans_q  <= chans_d;
      bits_q   <= bits_d;
      remain_q <= remain_d;
      low_q    <= low_d;
    end
  end

  // a pending low byte exists only while samples run or after the data ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bos_q |-> (phase_q == wpp_pkg::PH_SAMPLES || phase_q == wpp_pkg::PH_IDLE))
    else $error("low byte pending outside sample phase");

  // header offset stays inside the fixed header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == wpp_pkg::PH_HEADER) |-> (offset_q < {26'd0, wpp_pkg::HeaderLen}))
    else $error("header offset out of range");

  // samples only come from the sample phase without a restart
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && emit && res.kind == wpp_pkg::KIND_SAMPLE)
      |-> (phase_q == wpp_pkg::PH_SAMPLES && !item_i.file_start))
    else $error("sample emitted outside sample phase");

  // a stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !result_ready_i) |-> !advance)
    else $error("parser advanced over a stalled result");

endmodule

// ----- sv/wav_pcm_stream_parser.sv -----
// top level of the wav pcm stream parser: byte queue in front of the parser
//
// Input stream: one file byte per request on s_axis_tdata, with s_axis_tuser
// set on the first byte of a new file to restart parsing at offset zero.
// Output stream: one result per request. tuser carries the kind (sample,
// header done, missing data chunk, unsupported sample width) and the
// end-of-data flag; tlast marks the last channel of a frame. Header results
// carry sample rate, channel count and data length; sample results carry the
// 16-bit sample and its channel index. Fields that do not belong to a kind
// read zero.
// Path: an accepted byte is written into the queue, then parsed from the
// queue head into the output register, where its result appears.
// Throughput: one byte per cycle while the output register is not stalled
// by the receiver.
// Reset empties the queue, clears the output valid flag and returns the
// parser to the header phase. When the receiver stalls, the result holds in
// the output register, the parser stops and the two-entry queue fills before
// s_axis_tready drops.
module wav_pcm_stream_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [wpp_pkg::InDataW-1:0]   s_axis_tdata,  // data_byte[7:0]
  input  logic [wpp_pkg::InUserW-1:0]   s_axis_tuser,  // file_start[0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample[15:0], channel[31:16], sample_rate[63:32], channel_count[79:64],
  // data_bytes[111:80]
  output logic [wpp_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic [wpp_pkg::OutUserW-1:0]  m_axis_tuser,  // kind[1:0], data_last[2]
  output logic                          m_axis_tlast   // frame_last
);

  wpp_pkg::in_item_t in_item;
  wpp_pkg::in_item_t q_item;
  wpp_pkg::result_t  result;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;

  assign in_item.data_byte  = s_axis_tdata;
  assign in_item.file_start = s_axis_tuser[0];
  assign s_axis_tready      = !q_full;

  // front end queue
  wpp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s_axis_tvalid),
    .push_item_i (in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  // back end parser
  wpp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (q_valid),
    .item_i         (q_item),
    .item_pop_o     (q_pop),
    .result_valid_o (m_axis_tvalid),
    .result_o       (result),
    .result_ready_i (m_axis_tready)
  );

  // output packing
  assign m_axis_tdata = {result.data_bytes, result.channel_count, result.sample_rate,
                         result.channel, result.sample};
  assign m_axis_tuser = {result.data_last, result.kind};
  assign m_axis_tlast = result.frame_last;

endmodule

// ----- bench/wpp_result_checker.sv -----
// result checker for the wav pcm stream parser: tracks the parse, predicts and compares results
`timescale 1ns / 100ps

module wpp_result_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [wpp_pkg::InDataW-1:0]   s_axis_tdata,   // data_byte[7:0]
  input  logic [wpp_pkg::InUserW-1:0]   s_axis_tuser,   // file_start[0]
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // sample[15:0], channel[31:16], sample_rate[63:32], channel_count[79:64],
  // data_bytes[111:80]
  input  logic [wpp_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic [wpp_pkg::OutUserW-1:0]  m_axis_tuser,   // kind[1:0], data_last[2]
  input  logic                          m_axis_tlast,   // frame_last
  output int unsigned                   mismatches_o,
  output int unsigned                   results_pending_o,
  output int unsigned                   results_compared_o,
  output int unsigned                   error_reports_o
);

  // parser state as the stream should leave it
  wpp_pkg::phase_e phase_q;
  logic [31:0]     offset_q;
  logic [31:0]     window_q;
  logic [31:0]     shift_q;
  logic [31:0]     riff_size_q;
  logic [31:0]     rate_q;
  logic [31:0]     remaining_q;
  logic [15:0]     chans_q;
  logic [15:0]     bits_q;
  logic [15:0]     chan_idx_q;
  logic [7:0]      low_q;
  logic            odd_q;

  // results the parser still owes, oldest first
  wpp_pkg::result_t pending_results[$];

  int unsigned      mismatches;
  int unsigned      compared;
  int unsigned      error_reports;
  wpp_pkg::result_t want;
  logic             bad;

  task automatic clear_parser();
    phase_q     = wpp_pkg::PH_HEADER;
    offset_q    = '0;
    window_q    = '0;
    shift_q     = '0;
    riff_size_q = '0;
    rate_q      = '0;
    remaining_q = '0;
    chans_q     = '0;
    bits_q      = '0;
    chan_idx_q  = '0;
    low_q       = '0;
    odd_q       = 1'b0;
  endtask

  // one accepted byte: update the parse and queue any result it causes
  task automatic advance_parser(input logic [7:0] b, input logic start);
    wpp_pkg::result_t r;
    logic             produced;
    logic [16:0]      next_chan;
    r        = '0;
    produced = 1'b0;
    if (start) clear_parser();
    case (phase_q)
      wpp_pkg::PH_HEADER: begin
        // little-endian header fields at fixed offsets
        if (offset_q >= 4 && offset_q <= 7)
          riff_size_q |= {24'd0, b} << ((offset_q - 4) * 8);
        else if (offset_q == 22 || offset_q == 23)
          chans_q |= {8'd0, b} << ((offset_q - 22) * 8);
        else if (offset_q >= 24 && offset_q <= 27)
          rate_q |= {24'd0, b} << ((offset_q - 24) * 8);
        else if (offset_q == 34 || offset_q == 35)
          bits_q |= {8'd0, b} << ((offset_q - 34) * 8);
        if (offset_q + 1 >= {26'd0, wpp_pkg::HeaderLen}) begin
          phase_q  = wpp_pkg::PH_SEARCH;
          offset_q = {26'd0, wpp_pkg::HeaderLen};
          shift_q  = '0;
          window_q = '0;
        end else begin
          offset_q = offset_q + 1;
        end
      end
      wpp_pkg::PH_SEARCH: begin
        // sliding window, first compare once four bytes are in
        window_q = {window_q[23:0], b};
        if (shift_q < 3) begin
          shift_q = shift_q + 1;
        end else if (window_q == wpp_pkg::DataTag) begin
          phase_q     = wpp_pkg::PH_LENGTH;
          shift_q     = '0;
          remaining_q = '0;
        end else if (offset_q >= riff_size_q) begin
          phase_q  = wpp_pkg::PH_IDLE;
          r.kind   = wpp_pkg::KIND_NO_DATA;
          produced = 1'b1;
        end else begin
          offset_q = offset_q + 1;
        end
      end
      wpp_pkg::PH_LENGTH: begin
        remaining_q |= {24'd0, b} << shift_q[4:0];
        shift_q = shift_q + 8;
        if (shift_q >= 32) begin
          produced = 1'b1;
          if (bits_q != wpp_pkg::PcmBits) begin
            phase_q = wpp_pkg::PH_IDLE;
            r.kind  = wpp_pkg::KIND_BAD_WIDTH;
          end else begin
            r.kind          = wpp_pkg::KIND_HEADER;
            r.sample_rate   = rate_q;
            r.channel_count = chans_q;
            r.data_bytes    = remaining_q;
            phase_q         = (remaining_q == 0) ? wpp_pkg::PH_IDLE : wpp_pkg::PH_SAMPLES;
            odd_q           = 1'b0;
            chan_idx_q      = '0;
          end
        end
      end
      wpp_pkg::PH_SAMPLES: begin
        remaining_q = remaining_q - 1;
        if (!odd_q) begin
          // low byte; a lone last byte ends the chunk silently
          low_q = b;
          odd_q = 1'b1;
          if (remaining_q == 0) phase_q = wpp_pkg::PH_IDLE;
        end else begin
          odd_q          = 1'b0;
          next_chan      = {1'b0, chan_idx_q} + 17'd1;
          r.kind         = wpp_pkg::KIND_SAMPLE;
          r.sample       = {b, low_q};
          r.channel      = chan_idx_q;
          r.frame_last   = (next_chan >= {1'b0, chans_q});
          r.data_last    = (remaining_q == 0);
          produced       = 1'b1;
          chan_idx_q     = r.frame_last ? 16'd0 : next_chan[15:0];
          if (remaining_q == 0) phase_q = wpp_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase
    if (produced) pending_results.insert(pending_results.size(), r);
  endtask

  task automatic report_mismatch(input string what, input wpp_pkg::result_t exp_r,
                                 input logic has_exp);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s", $time, what);
      if (has_exp)
        $display("  expected kind=%0d sample=%0d channel=%0d frame_last=%0b data_last=%0b",
                 exp_r.kind, exp_r.sample, exp_r.channel, exp_r.frame_last, exp_r.data_last);
      if (has_exp)
        $display("           rate=%0d channels=%0d bytes=%0d",
                 exp_r.sample_rate, exp_r.channel_count, exp_r.data_bytes);
      $display("  actual   kind=%0d sample=%0d channel=%0d frame_last=%0b data_last=%0b",
               m_axis_tuser[1:0], $signed(m_axis_tdata[15:0]), m_axis_tdata[31:16],
               m_axis_tlast, m_axis_tuser[2]);
      $display("           rate=%0d channels=%0d bytes=%0d",
               m_axis_tdata[63:32], m_axis_tdata[79:64], m_axis_tdata[111:80]);
    end
  endtask

  // watch both streams at each rising edge; results first, as none can come from this edge's byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_parser();
      pending_results.delete();
      mismatches    = 0;
      compared      = 0;
      error_reports = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, 1'b0);
        end else begin
          want = pending_results.pop_front();
          compared++;
          if (want.kind == wpp_pkg::KIND_NO_DATA || want.kind == wpp_pkg::KIND_BAD_WIDTH)
            error_reports++;
          bad = (m_axis_tuser[1:0] !== want.kind)
             || (m_axis_tdata[15:0] !== want.sample)
             || (m_axis_tdata[31:16] !== want.channel)
             || (m_axis_tlast !== want.frame_last)
             || (m_axis_tuser[2] !== want.data_last)
             || (m_axis_tdata[63:32] !== want.sample_rate)
             || (m_axis_tdata[79:64] !== want.channel_count)
             || (m_axis_tdata[111:80] !== want.data_bytes);
          if (bad) report_mismatch("result differs from expectation", want, 1'b1);
        end
      end
      if (s_axis_tvalid && s_axis_tready) advance_parser(s_axis_tdata, s_axis_tuser[0]);
    end
    mismatches_o       <= mismatches;
    results_pending_o  <= pending_results.size();
    results_compared_o <= compared;
    error_reports_o    <= error_reports;
  end

endmodule

// ----- bench/tb_wav_pcm_stream_parser.sv -----
// testbench top for the wav pcm stream parser: file stimulus, handshake idling and verdict
`timescale 1ns / 100ps

module tb_wav_pcm_stream_parser;

  localparam int          RandomBytes = 760;
  localparam int          QuietLimit  = 2000;
  localparam int          DrainCycles = 10;
  localparam logic [31:0] TagRiff     = "RIFF";
  localparam logic [31:0] TagWave     = "WAVE";
  localparam logic [31:0] TagFmt      = "fmt ";
  localparam logic [31:0] TagList     = "LIST";
  localparam logic [31:0] TagJunk     = "junk";

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [wpp_pkg::InDataW-1:0]  s_axis_tdata  = '0;   // data_byte[7:0]
  logic [wpp_pkg::InUserW-1:0]  s_axis_tuser  = '0;   // file_start[0]
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  // sample[15:0], channel[31:16], sample_rate[63:32], channel_count[79:64],
  // data_bytes[111:80]
  logic [wpp_pkg::OutDataW-1:0] m_axis_tdata;
  logic [wpp_pkg::OutUserW-1:0] m_axis_tuser;         // kind[1:0], data_last[2]
  logic                         m_axis_tlast;         // frame_last

  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned results_compared;
  int unsigned error_reports;

  logic [7:0]  wav_bytes[$];
  int          bytes_sent   = 0;
  int          files_sent   = 0;
  int          stall_left   = 0;
  bit          tx_gaps_on   = 1'b0;
  bit          rx_stalls_on = 1'b0;

  wav_pcm_stream_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  wpp_result_checker u_result_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser),
    .m_axis_tlast       (m_axis_tlast),
    .mismatches_o       (mismatches),
    .results_pending_o  (results_pending),
    .results_compared_o (results_compared),
    .error_reports_o    (error_reports)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // receiver stalls
  always @(posedge clk_i) begin
    if (stall_left > 0) stall_left--;
    else if (rx_stalls_on && $urandom_range(0, 2) == 0) stall_left = pick_gap(1'b1);
    m_axis_tready <= (stall_left == 0);
  end

  // no request moved on either side for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no request moved for %0d cycles", QuietLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic set_idling(input bit tx_on, input bit rx_on);
    tx_gaps_on   = tx_on;
    rx_stalls_on <= rx_on;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    gap = pick_gap(tx_gaps_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // send up to limit queued bytes, restart flag on the first one if start is set
  task automatic send_wav(input logic start, input int limit);
    for (int i = 0; i < wav_bytes.size() && i < limit; i++)
      send_byte(wav_bytes[i], start && i == 0);
    wav_bytes.delete();
    files_sent++;
  endtask

  // append one byte to the file being built
  task automatic add_byte(input logic [7:0] v);
    wav_bytes.insert(wav_bytes.size(), v);
  endtask

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) add_byte(v[8*i +: 8]);
  endtask

  task automatic put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) add_byte(tag[8*i +: 8]);
  endtask

  task automatic put_noise(input int n);
    for (int i = 0; i < n; i++) add_byte(8'($urandom));
  endtask

  // pcm bytes biased toward the sign and range extremes
  task automatic put_pcm(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       add_byte(8'h00);
        1:       add_byte(8'hFF);
        2:       add_byte(8'h80);
        3:       add_byte(8'h7F);
        default: add_byte(8'($urandom));
      endcase
    end
  endtask

  // 36-byte riff/fmt header
  task automatic put_header(input logic [31:0] riff, input logic [15:0] chans,
                            input logic [31:0] rate, input logic [15:0] bits);
    put_tag(TagRiff);
    put_le(riff, 4);
    put_tag(TagWave);
    put_tag(TagFmt);
    put_le(32'd16, 4);
    put_le(32'd1, 2);
    put_le({16'd0, chans}, 2);
    put_le(rate, 4);
    put_le(rate * chans * 2, 4);
    put_le({15'd0, chans, 1'b0}, 2);
    put_le({16'd0, bits}, 2);
  endtask

  // random file: mostly well formed, some broken, truncated or without a data chunk
  task automatic random_wav();
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] rate;
    logic [31:0] riff;
    logic [31:0] len;
    int          filler;
    int          body;
    int          limit;
    int          r;
    logic        start;
    logic        has_tag;
    set_idling($urandom_range(0, 1), $urandom_range(0, 1));
    r = $urandom_range(0, 9);
    if (r == 0)     chans = 16'd0;
    else if (r < 8) chans = 16'($urandom_range(1, 3));
    else if (r < 9) chans = 16'($urandom_range(4, 8));
    else            chans = 16'($urandom);
    bits    = ($urandom_range(0, 7) == 0) ? 16'($urandom) : wpp_pkg::PcmBits;
    rate    = ($urandom_range(0, 1) == 0) ? 32'd48000 : 32'($urandom);
    filler  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    body    = $urandom_range(0, 36);
    len     = 32'(body);
    if ($urandom_range(0, 11) == 0) len = 32'($urandom);
    riff    = 32'(36 + filler + body);
    if ($urandom_range(0, 7) == 0) riff = 32'($urandom_range(0, 38 + filler));
    has_tag = ($urandom_range(0, 11) != 0);
    start   = ($urandom_range(0, 15) != 0);
    put_header(riff, chans, rate, bits);
    put_noise(filler);
    put_tag(has_tag ? wpp_pkg::DataTag : TagJunk);
    put_le(len, 4);
    put_pcm(body);
    limit = wav_bytes.size();
    if ($urandom_range(0, 9) == 0) limit = $urandom_range(1, wav_bytes.size());
    send_wav(start, limit);
    // stray bytes, now and then with a restart among them
    if ($urandom_range(0, 5) == 0) begin
      r = $urandom_range(1, 8);
      for (int i = 0; i < r; i++) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
    end
  endtask

  // stimulus and verdict
  initial begin
    int directed_bytes;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // data tag right after the header, sample extremes, no restart flag after reset
    set_idling(1'b0, 1'b0);
    put_header(32'd52, 16'd2, 32'd44100, wpp_pkg::PcmBits);
    put_tag(wpp_pkg::DataTag);
    put_le(32'd8, 4);
    put_le(32'h7FFF_8000, 4);
    put_le(32'h0000_FFFF, 4);
    send_wav(1'b0, wav_bytes.size());

    // 8-bit samples are refused; trailing bytes ignored while idle
    put_header(32'd44, 16'd1, 32'd8000, 16'd8);
    put_tag(wpp_pkg::DataTag);
    put_le(32'd4, 4);
    put_pcm(6);
    send_wav(1'b1, wav_bytes.size());

    // no data chunk before the chunk size runs out
    set_idling(1'b1, 1'b1);
    put_header(32'd40, 16'd1, 32'd22050, wpp_pkg::PcmBits);
    put_tag(TagList);
    put_le(32'd4, 4);
    put_le(32'd0, 4);
    put_le(32'd0, 4);
    send_wav(1'b1, wav_bytes.size());

    // empty data chunk
    put_header(32'd44, 16'd2, 32'd16000, wpp_pkg::PcmBits);
    put_tag(wpp_pkg::DataTag);
    put_le(32'd0, 4);
    put_pcm(3);
    send_wav(1'b1, wav_bytes.size());

    // odd data length leaves a lone byte
    put_header(32'd41, 16'd1, 32'd11025, wpp_pkg::PcmBits);
    put_tag(wpp_pkg::DataTag);
    put_le(32'd5, 4);
    put_pcm(7);
    send_wav(1'b1, wav_bytes.size());

    // zero channels: every sample closes a frame
    set_idling(1'b0, 1'b1);
    put_header(32'd42, 16'd0, 32'd32000, wpp_pkg::PcmBits);
    put_tag(wpp_pkg::DataTag);
    put_le(32'd6, 4);
    put_pcm(6);
    send_wav(1'b1, wav_bytes.size());

    // largest header fields, cut off by a restart mid-data
    put_header(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, wpp_pkg::PcmBits);
    put_tag(wpp_pkg::DataTag);
    put_le(32'hFFFF_FFFF, 4);
    put_pcm(10);
    send_wav(1'b1, wav_bytes.size());

    // restart in the middle of a header
    set_idling(1'b1, 1'b0);
    put_header(32'd60, 16'd2, 32'd48000, wpp_pkg::PcmBits);
    send_wav(1'b1, 20);

    // zero chunk size: the first window already gives up
    put_header(32'd0, 16'd2, 32'd48000, wpp_pkg::PcmBits);
    put_tag(TagList);
    put_tag(wpp_pkg::DataTag);
    put_le(32'd2, 4);
    put_pcm(2);
    send_wav(1'b1, wav_bytes.size());

    // data chunk found behind another chunk
    set_idling(1'b1, 1'b1);
    put_header(32'd60, 16'd3, 32'd96000, wpp_pkg::PcmBits);
    put_tag(TagList);
    put_le(32'd4, 4);
    put_noise(4);
    put_tag(wpp_pkg::DataTag);
    put_le(32'd12, 4);
    put_pcm(12);
    send_wav(1'b1, wav_bytes.size());

    directed_bytes = bytes_sent;
    while (bytes_sent < directed_bytes + RandomBytes) random_wav();
    s_axis_tvalid <= 1'b0;

    // drain outstanding results, then watch for strays
    do @(posedge clk_i); while (results_pending != 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("streamed %0d bytes in %0d files, %0d results compared",
             bytes_sent, files_sent, results_compared);
    $display("%0d of those results were missing-chunk or bad-width reports", error_reports);
    if (mismatches == 0 && results_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, results_pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- wav_pcm_stream_parser.f -----
sv/wpp_pkg.sv
sv/wpp_queue.sv
sv/wpp_parser.sv
sv/wav_pcm_stream_parser.sv
bench/wpp_result_checker.sv
bench/tb_wav_pcm_stream_parser.sv
